// ===== design/csre_pkg.sv =====
`default_nettype none

package csre_pkg;

  // Number of payload bytes that are walked (2 to 8).
  localparam int PAYLOAD_BYTES = 8;
  localparam int PL_W          = PAYLOAD_BYTES * 8;
  localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
  // Position counter must also hold PAYLOAD_BYTES itself.
  localparam int POS_W         = $clog2(PAYLOAD_BYTES + 1);

  // Depth of the frame queue between classifier and walker (power of two).
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] TAG_END     = 8'h00;
  localparam logic [7:0] TAG_SPEED   = 8'h51;
  localparam logic [7:0] TAG_BATTERY = 8'h61;
  localparam logic [7:0] TAG_BRAKE   = 8'h30;
  localparam logic [7:0] TAG_DIR     = 8'hC6;

  localparam logic [1:0] KIND_SPEED   = 2'd0;
  localparam logic [1:0] KIND_BATTERY = 2'd1;
  localparam logic [1:0] KIND_BRAKE   = 2'd2;
  localparam logic [1:0] KIND_DIR     = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_MATCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNC_MASK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNC_MATCH = 3'd3;

  // One queue entry, or the push/head side of the queue.
  typedef struct packed {
    logic            vld;
    logic [PL_W-1:0] pl;
  } csre_q_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
  } csre_kind_t;

  typedef enum logic {
    WK_IDLE,
    WK_WALK
  } csre_wk_state_t;

  function automatic csre_kind_t tag_kind(input logic [7:0] tag);
    csre_kind_t res;
    res.hit  = 1'b1;
    res.kind = KIND_SPEED;
    unique case (tag)
      TAG_SPEED:   res.kind = KIND_SPEED;
      TAG_BATTERY: res.kind = KIND_BATTERY;
      TAG_BRAKE:   res.kind = KIND_BRAKE;
      TAG_DIR:     res.kind = KIND_DIR;
      default:     res.hit  = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/csre_front.sv =====
`default_nettype none

module csre_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [csre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [31:0]                    in_frame_id,
  input  wire logic [63:0]                    in_payload,
  output csre_pkg::csre_q_t                   q_push,
  input  wire logic                           q_ready
);
  import csre_pkg::*;

  logic [31:0] node_mask_r;
  logic [15:0] node_match_r;
  logic [31:0] func_mask_r;
  logic [15:0] func_match_r;
  logic [31:0] node_sel;
  logic [31:0] func_sel;
  logic        pass;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_mask_r  <= '0;
      node_match_r <= '0;
      func_mask_r  <= '0;
      func_match_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_MASK:  node_mask_r  <= cfg_wdata;
        CFG_NODE_MATCH: node_match_r <= cfg_wdata[15:0];
        CFG_FUNC_MASK:  func_mask_r  <= cfg_wdata;
        CFG_FUNC_MATCH: func_match_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Only the low 16 bits of each masked identifier take part in the compare.
  assign node_sel = in_frame_id & node_mask_r;
  assign func_sel = in_frame_id & func_mask_r;
  assign pass     = (node_sel[15:0] == node_match_r) && (func_sel[15:0] == func_match_r);

  assign in_ready   = q_ready;
  assign q_push.vld = in_valid && q_ready && pass;
  assign q_push.pl  = in_payload[PL_W-1:0];

endmodule

`default_nettype wire

// ===== design/csre_fifo.sv =====
`default_nettype none

module csre_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire csre_pkg::csre_q_t push,
  output logic                   push_ready,
  output csre_pkg::csre_q_t      head,
  input  wire logic              pop
);
  import csre_pkg::*;

  logic [PL_W-1:0]   mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != QCNT_W'(Q_DEPTH));
  assign head.vld   = (cnt_r != '0);
  assign head.pl    = mem_r[rd_ptr_r];
  assign do_push    = push.vld && push_ready;
  assign do_pop     = pop && head.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.pl;
    end
  end

endmodule

`default_nettype wire

// ===== design/csre_walker.sv =====
`default_nettype none

module csre_walker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire csre_pkg::csre_q_t head,
  output logic                   pop,
  output logic                   busy,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_reading_kind,
  output logic [7:0]             out_reading_value,
  output logic                   out_last_reading
);
  import csre_pkg::*;

  csre_wk_state_t  state_r, state_nxt;
  logic [PL_W-1:0] pl_r, pl_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic            pend_vld_r, pend_vld_nxt;
  logic [1:0]      pend_kind_r, pend_kind_nxt;
  logic [7:0]      pend_val_r, pend_val_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_kind_r, out_kind_nxt;
  logic [7:0]      out_val_r, out_val_nxt;
  logic            out_last_r, out_last_nxt;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] vidx;
  logic             in_range;
  logic [7:0]       tag;
  logic [7:0]       val;
  csre_kind_t       tk;
  logic             end_walk;
  logic             out_free;

  assign idx      = pos_r[IDX_W-1:0];
  assign vidx     = idx + 1'b1;
  assign in_range = (pos_r < POS_W'(PAYLOAD_BYTES));
  assign tag      = in_range ? pl_r[{idx, 3'b000} +: 8] : TAG_END;
  assign val      = pl_r[{vidx, 3'b000} +: 8];
  assign tk       = tag_kind(tag);
  // A sensor tag in the final byte has no value byte and closes the walk.
  assign end_walk = (tag == TAG_END) || (tk.hit && (pos_r == POS_W'(PAYLOAD_BYTES - 1)));
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= WK_IDLE;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pl_r        <= pl_nxt;
    pos_r       <= pos_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_val_r  <= pend_val_nxt;
    out_kind_r  <= out_kind_nxt;
    out_val_r   <= out_val_nxt;
    out_last_r  <= out_last_nxt;
  end

  // The newest reading waits in the pending register until the walk shows
  // whether another one follows, which settles its last flag.
  always_comb begin
    state_nxt     = state_r;
    pl_nxt        = pl_r;
    pos_nxt       = pos_r;
    pend_vld_nxt  = pend_vld_r;
    pend_kind_nxt = pend_kind_r;
    pend_val_nxt  = pend_val_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      WK_IDLE: begin
        if (head.vld) begin
          pop          = 1'b1;
          pl_nxt       = head.pl;
          pos_nxt      = '0;
          pend_vld_nxt = 1'b0;
          state_nxt    = WK_WALK;
        end
      end
      WK_WALK: begin
        if (end_walk) begin
          if (!pend_vld_r) begin
            state_nxt = WK_IDLE;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = pend_kind_r;
            out_val_nxt   = pend_val_r;
            out_last_nxt  = 1'b1;
            pend_vld_nxt  = 1'b0;
            state_nxt     = WK_IDLE;
          end
        end else if (tk.hit) begin
          if (!pend_vld_r || out_free) begin
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pend_kind_r;
              out_val_nxt   = pend_val_r;
              out_last_nxt  = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_kind_nxt = tk.kind;
            pend_val_nxt  = val;
            pos_nxt       = pos_r + POS_W'(2);
          end
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      default: state_nxt = WK_IDLE;
    endcase
  end

  assign busy              = (state_r == WK_WALK);
  assign out_valid         = out_valid_r;
  assign out_reading_kind  = out_kind_r;
  assign out_reading_value = out_val_r;
  assign out_last_reading  = out_last_r;

endmodule

`default_nettype wire

// ===== design/can_sensor_record_extractor.sv =====
`default_nettype none

// CAN sensor record extractor. Each input item is one CAN frame: the 32-bit
// identifier word and eight payload bytes, byte 0 in bits 7:0. The frame is
// kept when the identifier ANDed with node_mask, cut to 16 bits, equals
// node_match, and the identifier ANDed with func_mask, cut to 16 bits, equals
// func_match; other frames vanish without any result. A kept frame's payload
// is walked from byte 0 as tag records: tag 0x00 ends the walk, the sensor
// tags 0x51 (speed), 0x61 (battery), 0x30 (brake pressure) and 0xC6
// (direction) take the following byte as their value and give one result
// item, and any other tag skips a single byte. The walk also stops at the
// end of the payload, and a sensor tag in the final byte gives nothing. The
// last result item of a frame carries out_last_reading high; a frame may
// give none at all. The classifier takes one frame per cycle, kept or
// rejected, while the two-entry frame queue has room. The walker takes a
// skipped byte or a sensor tag with its value at each step, may stall while
// the output register is still held by the consumer, and takes the next
// frame from the queue only once the walk of the previous one has closed. The
// configuration registers are written through cfg_we, cfg_index and
// cfg_wdata (0 node_mask, 1 node_match, 2 func_mask, 3 func_match; other
// indexes are ignored); the user must write them only while no frame is in
// flight, and the block itself does not enforce this.
module can_sensor_record_extractor (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [csre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [31:0]                    in_frame_id,
  input  wire logic [63:0]                    in_payload,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          out_reading_kind,
  output logic [7:0]                          out_reading_value,
  output logic                                out_last_reading
);
  import csre_pkg::*;

  csre_q_t q_push;
  csre_q_t q_head;
  logic    q_ready;
  logic    q_pop;
  logic    wk_busy;

  // Front end: configuration registers and the identifier filter.
  csre_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_frame_id (in_frame_id),
    .in_payload  (in_payload),
    .q_push      (q_push),
    .q_ready     (q_ready)
  );

  // Short queue of kept payloads, so that filtering and walking stall apart.
  csre_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .head       (q_head),
    .pop        (q_pop)
  );

  // Back end: walks the tag records of each kept payload.
  csre_walker u_walker (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .pop               (q_pop),
    .busy              (wk_busy),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reading_kind  (out_reading_kind),
    .out_reading_value (out_reading_value),
    .out_last_reading  (out_last_reading)
  );

  // A frame enters the queue only on an accepted input item.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push.vld |-> (in_valid && in_ready))
    else $error("frame queued without an accepted input item");

  // The walker takes a new frame only when it has finished the previous one.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !wk_busy)
    else $error("queue popped while the walker was busy");

  // Every walk starts with a frame taken from the queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(wk_busy) |-> $past(q_pop && q_head.vld))
    else $error("walk started without a queued frame");

  // No result is offered straight after reset.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

`default_nettype wire

// ===== dv/can_sensor_record_extractor_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the CAN sensor record extractor.
//
// Frames are queued by the stimulus process and handed to the block by a
// clocked driver; readings leaving the block are compared by a clocked
// monitor against a queue of readings that the bench works out for itself
// whenever a frame item is accepted. The filter registers are only
// rewritten once the block has gone quiet.
module can_sensor_record_extractor_tb;
  import csre_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 5;
  // The frame being walked and two queued frames, each with its hand-over
  // and its walk, may still be in flight once the last reading has come
  // out.
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 50;
  localparam int MAX_READINGS   = 4;
  localparam int REPORT_LINES   = 100;

  // Indexes that decode to no register at all.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] payload;
  } can_frame_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } reading_t;

  // How the filter is set up for a random phase.
  typedef enum int {
    FILTER_OPEN,
    FILTER_FULL,
    FILTER_SPARSE,
    FILTER_RANDOM
  } filter_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_frame_id = '0;
  logic [63:0] in_payload = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_reading_kind;
  logic [7:0]  out_reading_value;
  logic        out_last_reading;

  // The bench's own copy of the filter registers, all zero after reset.
  logic [31:0] node_mask_q = '0;
  logic [15:0] node_match_q = '0;
  logic [31:0] func_mask_q = '0;
  logic [15:0] func_match_q = '0;

  can_frame_t pending_frames [$];
  reading_t   readings_due [$];
  can_frame_t next_frame;
  reading_t   want;

  int idle_pct = 0;
  int send_hold = 0;
  int recv_hold = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int frames_sent = 0;
  int frames_kept = 0;
  int readings_checked = 0;
  int cfg_settings = 0;

  can_sensor_record_extractor dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_frame_id       (in_frame_id),
    .in_payload        (in_payload),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reading_kind  (out_reading_kind),
    .out_reading_value (out_reading_value),
    .out_last_reading  (out_last_reading)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Counts the mismatch; only the first lines are printed so that a badly
  // broken block does not flood the log.
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LINES) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  // Works out the readings that one accepted frame must give and appends
  // them to the queue of readings due. A frame is kept only when both masked
  // identifiers, cut to 16 bits, equal their match values. The payload is
  // then walked from byte 0: a zero tag ends the walk, a sensor tag takes
  // the next byte as its value, any other tag moves on by one byte. A sensor
  // tag in the final byte has no value byte and simply ends the walk.
  task automatic predict_readings(input logic [31:0] id, input logic [63:0] pl);
    reading_t    found [MAX_READINGS];
    logic [31:0] node_bits;
    logic [31:0] func_bits;
    logic [7:0]  tag;
    logic [1:0]  kind;
    bit          is_sensor;
    int          pos;
    int          count;
    int          i;
    node_bits = id & node_mask_q;
    func_bits = id & func_mask_q;
    if (node_bits[15:0] != node_match_q || func_bits[15:0] != func_match_q) begin
      return;
    end
    frames_kept++;
    pos = 0;
    count = 0;
    while (pos < PAYLOAD_BYTES && count < MAX_READINGS) begin
      tag = pl[pos*8 +: 8];
      if (tag == TAG_END) break;
      is_sensor = 1'b1;
      kind = KIND_SPEED;
      case (tag)
        TAG_SPEED:   kind = KIND_SPEED;
        TAG_BATTERY: kind = KIND_BATTERY;
        TAG_BRAKE:   kind = KIND_BRAKE;
        TAG_DIR:     kind = KIND_DIR;
        default:     is_sensor = 1'b0;
      endcase
      if (!is_sensor) begin
        pos++;
      end else if (pos + 1 >= PAYLOAD_BYTES) begin
        break;
      end else begin
        found[count] = {kind, pl[(pos+1)*8 +: 8], 1'b0};
        count++;
        pos += 2;
      end
    end
    if (count > 0) found[count-1].last = 1'b1;
    for (i = 0; i < count; i++) readings_due.push_back(found[i]);
  endtask

  // Driver: offers queued frames one item at a time. Valid is only dropped
  // once the current item has gone, so gaps start after an acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_readings(in_frame_id, in_payload);
        frames_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_hold > 0) begin
          send_hold--;
          in_valid <= 1'b0;
        end else if (pending_frames.size() == 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
          send_hold = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else begin
          next_frame = pending_frames.pop_front();
          in_valid <= 1'b1;
          in_frame_id <= next_frame.id;
          in_payload <= next_frame.payload;
        end
      end
    end
  end

  // Monitor: checks each accepted reading against the oldest one due and
  // stalls the block in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (readings_due.size() == 0) begin
          report_mismatch($sformatf("reading with none due: kind %0d value %02h last %0b",
                                    out_reading_kind, out_reading_value, out_last_reading));
        end else begin
          want = readings_due.pop_front();
          if (out_reading_kind !== want.kind) begin
            report_mismatch($sformatf("reading %0d: kind %0d, expected %0d",
                                      readings_checked, out_reading_kind, want.kind));
          end
          if (out_reading_value !== want.value) begin
            report_mismatch($sformatf("reading %0d: value %02h, expected %02h",
                                      readings_checked, out_reading_value, want.value));
          end
          if (out_last_reading !== want.last) begin
            report_mismatch($sformatf("reading %0d: last flag %0b, expected %0b",
                                      readings_checked, out_last_reading, want.last));
          end
          readings_checked++;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        recv_hold = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any stretch without a single accepted item on either side
  // that runs past the limit means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("[can_sensor_record_extractor] ERROR");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_NODE_MASK:  node_mask_q = data;
      CFG_NODE_MATCH: node_match_q = data[15:0];
      CFG_FUNC_MASK:  func_mask_q = data;
      CFG_FUNC_MATCH: func_match_q = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_filter(input logic [31:0] nmask, input logic [15:0] nmatch,
                            input logic [31:0] fmask, input logic [15:0] fmatch);
    write_reg(CFG_NODE_MASK, nmask);
    write_reg(CFG_NODE_MATCH, {16'h0, nmatch});
    write_reg(CFG_FUNC_MASK, fmask);
    write_reg(CFG_FUNC_MATCH, {16'h0, fmatch});
    cfg_settings++;
  endtask

  function automatic void queue_frame(input logic [31:0] id, input logic [63:0] pl);
    pending_frames.push_back({id, pl});
  endfunction

  // Waits until every queued item has been taken and every reading due has
  // come out, then lets a frame that gives nothing finish its walk.
  task automatic settle();
    while (pending_frames.size() != 0 || in_valid || readings_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed tag records with random values; a tenth of the
  // payloads are pure noise. Bytes past an end tag stay random, as do the
  // value bytes, so a value byte may well look like a tag.
  function automatic logic [63:0] make_payload();
    logic [63:0] pl;
    logic [7:0]  b;
    logic [1:0]  k;
    int          pos;
    int          pick;
    pl = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return pl;
    pos = 0;
    while (pos < 8) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        k = 2'($urandom_range(0, 3));
        case (k)
          KIND_SPEED:   b = TAG_SPEED;
          KIND_BATTERY: b = TAG_BATTERY;
          KIND_BRAKE:   b = TAG_BRAKE;
          default:      b = TAG_DIR;
        endcase
        pl[pos*8 +: 8] = b;
        pos += 2;
      end else if (pick < 18) begin
        b = TAG_SPEED;
        while (b == TAG_SPEED || b == TAG_BATTERY || b == TAG_BRAKE || b == TAG_DIR) begin
          b = 8'($urandom_range(1, 255));
        end
        pl[pos*8 +: 8] = b;
        pos++;
      end else begin
        pl[pos*8 +: 8] = TAG_END;
        break;
      end
    end
    return pl;
  endfunction

  // One random phase: set the filter from a random base identifier so that,
  // but for FILTER_RANDOM, most frames pass it, then send frames that either
  // agree with the base on every masked bit of the low 16 or are entirely random.
  task automatic run_random_phase(input filter_style_t style, input int pct);
    logic [31:0] base;
    logic [31:0] care;
    logic [31:0] nmask;
    logic [31:0] fmask;
    logic [31:0] id;
    logic [15:0] nmatch;
    logic [15:0] fmatch;
    int          i;
    base = $urandom;
    case (style)
      FILTER_OPEN: begin
        nmask = '0;
        fmask = '0;
      end
      FILTER_FULL: begin
        nmask = '1;
        fmask = '1;
      end
      FILTER_SPARSE: begin
        nmask = $urandom & $urandom;
        fmask = $urandom & $urandom;
      end
      default: begin
        nmask = $urandom;
        fmask = $urandom;
      end
    endcase
    nmatch = base[15:0] & nmask[15:0];
    fmatch = base[15:0] & fmask[15:0];
    // Match values with bits outside their mask: hardly anything passes.
    if (style == FILTER_RANDOM) begin
      nmatch = 16'($urandom);
      fmatch = 16'($urandom);
    end
    care = {16'h0, nmask[15:0] | fmask[15:0]};
    set_filter(nmask, nmatch, fmask, fmatch);
    idle_pct = pct;
    @(negedge clk);
    for (i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        id = $urandom;
      end else begin
        id = ($urandom & ~care) | (base & care);
      end
      queue_frame(id, make_payload());
    end
    settle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at their reset value: every frame passes the filter, so the
    // walk itself is exercised first. Payload byte 0 is the rightmost byte.
    idle_pct = 20;
    @(negedge clk);
    queue_frame(32'h0000_0000, 64'h0000_0000_0000_0000);  // empty frame
    queue_frame(32'hFFFF_FFFF, 64'h80C6_7F30_FF61_0051);  // all four sensors
    queue_frame(32'h1234_5678, 64'h0000_0000_2251_0102);  // unknown tags first
    queue_frame(32'h0000_0001, 64'h5101_0101_0101_0101);  // sensor tag in last byte
    queue_frame(32'h8000_0000, 64'hAB61_0101_0101_0101);  // value in last byte
    queue_frame(32'hA5A5_A5A5, 64'hFFFF_FFFF_FFFF_FFFF);  // no end tag, nothing
    queue_frame(32'h5A5A_5A5A, 64'h0000_0000_0030_5151);  // value that looks a tag
    queue_frame(32'h0000_FFFF, 64'h0000_0000_5100_33C6);  // end tag after reading
    queue_frame(32'hFFFF_0000, 64'h0000_09C6_FE05_3001);  // mixed records
    queue_frame(32'h7FFF_FFFF, 64'h00C6_0061_0051_0030);  // zero values
    queue_frame(32'h0F0F_0F0F, 64'h3030_3030_3030_3030);  // four brake readings
    settle();

    // Every mask and match bit set; writes to unused indexes must change
    // nothing.
    set_filter('1, 16'hFFFF, '1, 16'hFFFF);
    write_reg(CFG_SPARE_FIRST, 32'h0000_0000);
    write_reg(CFG_SPARE_LAST, 32'h0000_0000);
    @(negedge clk);
    queue_frame(32'hFFFF_FFFF, 64'h80C6_7F30_FF61_0051);
    queue_frame(32'h0000_FFFF, 64'h0000_0000_2251_0102);
    queue_frame(32'hFFFF_0000, 64'h3030_3030_3030_3030);  // rejected
    queue_frame(32'hFFFF_7FFF, 64'h3030_3030_3030_3030);  // rejected
    settle();

    // Disjoint node and function fields; bits above 15 of either mask must
    // play no part. One frame fails on the node field only, one on the
    // function field only.
    set_filter(32'hA5A5_07F0, 16'h0120, 32'h0000_F00F, 16'h3005);
    @(negedge clk);
    queue_frame(32'hDEAD_3125, 64'hAB61_0101_0101_0101);
    queue_frame(32'h0000_3135, 64'h3030_3030_3030_3030);  // node mismatch
    queue_frame(32'h0000_3124, 64'h3030_3030_3030_3030);  // function mismatch
    queue_frame(32'hFFFF_3125, 64'h3030_3030_3030_3030);
    settle();

    // Random phases with varying filters and back-pressure. The last one
    // runs at full rate on both sides.
    run_random_phase(FILTER_OPEN, 15);
    run_random_phase(FILTER_FULL, 30);
    run_random_phase(FILTER_SPARSE, 0);
    run_random_phase(FILTER_SPARSE, 50);
    run_random_phase(FILTER_RANDOM, 20);
    run_random_phase(FILTER_SPARSE, 10);
    run_random_phase(FILTER_FULL, 0);

    $display("covered %0d frames, %0d of them past the filter, under %0d filter settings",
             frames_sent, frames_kept, cfg_settings);
    $display("compared %0d readings, %0d mismatches", readings_checked, mismatches);
    if (mismatches == 0) begin
      $display("[can_sensor_record_extractor] OK");
    end else begin
      $display("[can_sensor_record_extractor] ERROR");
    end
    $finish;
  end

endmodule

// ===== can_sensor_record_extractor.f =====
design/csre_pkg.sv
design/csre_front.sv
design/csre_fifo.sv
design/csre_walker.sv
design/can_sensor_record_extractor.sv
dv/can_sensor_record_extractor_tb.sv
